@@ sv/smap_pkg.sv @@
// Shared types and constants for the serial-loaded bank mapper.
`timescale 1ns / 1ps
package smap_pkg;

  localparam int unsigned AddrW   = 16;
  localparam int unsigned DataW   = 8;
  localparam int unsigned MapW    = 19;
  localparam int unsigned PrgCfgW = 6;
  localparam int unsigned ChrCfgW = 5;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDatW = 6;

  localparam logic [PrgCfgW-1:0] PrgBanksReset = 6'd16;
  localparam logic [ChrCfgW-1:0] ChrBanksReset = 5'd0;

  typedef enum logic [1:0] {
    MODE_CPU_READ  = 2'd0,
    MODE_CPU_WRITE = 2'd1,
    MODE_PATTERN   = 2'd2,
    MODE_NAMETABLE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    TGT_NONE    = 3'd0,
    TGT_PRG_ROM = 3'd1,
    TGT_PRG_RAM = 3'd2,
    TGT_CHR_ROM = 3'd3,
    TGT_CHR_RAM = 3'd4,
    TGT_NT      = 3'd5
  } target_e;

  typedef enum logic [1:0] {
    REG_CONTROL = 2'd0,
    REG_CHR0    = 2'd1,
    REG_CHR1    = 2'd2,
    REG_PRG     = 2'd3
  } reg_sel_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PRG_BANKS = 1'd0,
    CFG_CHR_BANKS = 1'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [4:0] shift_value;
    logic [2:0] shift_count;
    logic [1:0] mirroring;
    logic [1:0] prg_mode;
    logic       chr_4k_mode;
    logic [4:0] chr_bank_low;
    logic [4:0] chr_bank_high;
    logic [4:0] prg_bank;
    logic       ram_enabled;
  } map_regs_t;

  typedef struct packed {
    logic [PrgCfgW-1:0] prg_rom_banks;
    logic [ChrCfgW-1:0] chr_rom_banks;
  } map_cfg_t;

  typedef struct packed {
    target_e         target;
    logic [MapW-1:0] mapped_address;
    logic            register_loaded;
  } map_result_t;

  localparam map_regs_t RegsReset = '{
    shift_value:   5'd0,
    shift_count:   3'd0,
    mirroring:     2'd1,
    prg_mode:      2'd3,
    chr_4k_mode:   1'b0,
    chr_bank_low:  5'd0,
    chr_bank_high: 5'd0,
    prg_bank:      5'd0,
    ram_enabled:   1'b1
  };

endpackage

@@ sv/smap_xlate.sv @@
// Address translation and serial register update for one access.
`timescale 1ns / 1ps
module smap_xlate (
  input  smap_pkg::map_regs_t               regs_i,
  input  smap_pkg::map_cfg_t                cfg_i,
  input  logic [1:0]                        mode_i,
  input  logic [smap_pkg::AddrW-1:0]        address_i,
  input  logic [smap_pkg::DataW-1:0]        data_i,
  output smap_pkg::map_regs_t               regs_o,
  output smap_pkg::map_result_t             result_o
);
  import smap_pkg::*;

  logic [4:0]  prg_mask;
  logic [3:0]  prg_inner;
  logic [4:0]  prg_outer;
  logic [4:0]  prg_sel;
  logic [4:0]  prg_bank_num;
  logic [4:0]  chr_mask;
  logic [4:0]  chr_bank_num;
  logic [4:0]  shift_next;
  logic [2:0]  count_next;
  logic        page;
  logic        is_high;
  target_e     cpu_tgt;
  logic [MapW-1:0] cpu_off;
  mode_e       mode;

  assign mode    = mode_e'(mode_i);
  assign is_high = address_i[15];

  // PRG bank selection, decoded from the live registers.
  always_comb begin
    prg_mask  = cfg_i.prg_rom_banks[4:0] - 5'd1;
    prg_inner = prg_mask[3:0];
    prg_outer = prg_mask[4] ? {regs_i.chr_bank_low[4], 4'd0} : 5'd0;
    prg_sel   = {1'b0, regs_i.prg_bank[3:0] & prg_inner};
    if (regs_i.prg_mode[1] == 1'b0) begin
      prg_bank_num = prg_outer | {1'b0, prg_sel[3:1], address_i[14]};
    end else if (regs_i.prg_mode == 2'd2) begin
      prg_bank_num = address_i[14] ? (prg_outer | prg_sel) : prg_outer;
    end else begin
      prg_bank_num = address_i[14] ? (prg_outer | {1'b0, prg_inner})
                                   : (prg_outer | prg_sel);
    end
  end

  always_comb begin
    cpu_tgt = TGT_NONE;
    cpu_off = '0;
    if (is_high) begin
      cpu_tgt = TGT_PRG_ROM;
      cpu_off = {prg_bank_num, address_i[13:0]};
    end else if (address_i[14:13] == 2'b11 && regs_i.ram_enabled) begin
      cpu_tgt = TGT_PRG_RAM;
      cpu_off = {6'd0, address_i[12:0]};
    end
  end

  always_comb begin
    chr_mask = {cfg_i.chr_rom_banks[3:0], 1'b0} - 5'd1;
    if (regs_i.chr_4k_mode) begin
      chr_bank_num = address_i[12] ? regs_i.chr_bank_high : regs_i.chr_bank_low;
    end else begin
      chr_bank_num = {regs_i.chr_bank_low[4:1], address_i[12]};
    end
    if (cfg_i.chr_rom_banks != '0) begin
      chr_bank_num = chr_bank_num & chr_mask;
    end else begin
      chr_bank_num = {4'd0, chr_bank_num[0]};
    end
  end

  always_comb begin
    unique case (regs_i.mirroring)
      2'd0:    page = 1'b0;
      2'd1:    page = 1'b1;
      2'd2:    page = address_i[10];
      default: page = address_i[11];
    endcase
  end

  assign shift_next = {data_i[0], regs_i.shift_value[4:1]};
  assign count_next = regs_i.shift_count + 3'd1;

  always_comb begin
    regs_o   = regs_i;
    result_o = '{target: TGT_NONE, mapped_address: '0, register_loaded: 1'b0};
    unique case (mode)
      MODE_CPU_READ: begin
        result_o.target         = cpu_tgt;
        result_o.mapped_address = cpu_off;
      end
      MODE_CPU_WRITE: begin
        if (!is_high) begin
          result_o.target         = cpu_tgt;
          result_o.mapped_address = cpu_off;
        end else if (data_i[7]) begin
          regs_o.shift_value = '0;
          regs_o.shift_count = '0;
          regs_o.prg_mode    = 2'd3;
        end else begin
          regs_o.shift_value = shift_next;
          regs_o.shift_count = count_next;
          if (count_next >= 3'd5) begin
            regs_o.shift_value       = '0;
            regs_o.shift_count       = '0;
            result_o.register_loaded = 1'b1;
            unique case (reg_sel_e'(address_i[14:13]))
              REG_CONTROL: begin
                regs_o.mirroring   = shift_next[1:0];
                regs_o.prg_mode    = shift_next[3:2];
                regs_o.chr_4k_mode = shift_next[4];
              end
              REG_CHR0: regs_o.chr_bank_low  = shift_next;
              REG_CHR1: regs_o.chr_bank_high = shift_next;
              default: begin
                regs_o.prg_bank    = shift_next;
                regs_o.ram_enabled = ~shift_next[4];
              end
            endcase
          end
        end
      end
      MODE_PATTERN: begin
        result_o.target         = (cfg_i.chr_rom_banks != '0) ? TGT_CHR_ROM : TGT_CHR_RAM;
        result_o.mapped_address = {2'd0, chr_bank_num, address_i[11:0]};
      end
      default: begin
        result_o.target         = TGT_NT;
        result_o.mapped_address = {8'd0, page, address_i[9:0]};
      end
    endcase
  end

endmodule

@@ sv/serial_loaded_bank_mapper.sv @@
// Top level of the serial-loaded bank mapper: item pipeline and state registers.
// Each accepted item is held in the input register, and its result is registered in the output register.
// Throughput: one item per cycle; the input stalls only while both registers are full.
// Each item sees the mapper state left by all earlier items.
// Reset sets the mapper registers and sizes to their power-on values at once.
`timescale 1ns / 1ps
module serial_loaded_bank_mapper (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    mode_i,
  input  logic [smap_pkg::AddrW-1:0]    address_i,
  input  logic [smap_pkg::DataW-1:0]    data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    target_o,
  output logic [smap_pkg::MapW-1:0]     mapped_address_o,
  output logic                          register_loaded_o,
  input  logic                          cfg_we_i,
  input  logic [smap_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [smap_pkg::CfgDatW-1:0]  cfg_data_i
);
  import smap_pkg::*;

  logic            s1_valid_q;
  logic [1:0]      mode_q;
  logic [AddrW-1:0] address_q;
  logic [DataW-1:0] data_q;
  logic            out_valid_q;
  map_result_t     result_q, result_d;
  map_regs_t       regs_q, regs_d;
  map_cfg_t        cfg_q;
  logic            out_ready;
  logic            s1_fire;
  logic            in_fire;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!s1_valid_q || out_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q    <= mode_i;
      address_q <= address_i;
      data_q    <= data_i;
    end
    if (s1_fire) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= RegsReset;
      cfg_q  <= '{prg_rom_banks: PrgBanksReset, chr_rom_banks: ChrBanksReset};
    end else begin
      if (s1_fire) begin
        regs_q <= regs_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_PRG_BANKS: cfg_q.prg_rom_banks <= cfg_data_i[PrgCfgW-1:0];
          default:       cfg_q.chr_rom_banks <= cfg_data_i[ChrCfgW-1:0];
        endcase
      end
    end
  end

  smap_xlate u_xlate (
    .regs_i    (regs_q),
    .cfg_i     (cfg_q),
    .mode_i    (mode_q),
    .address_i (address_q),
    .data_i    (data_q),
    .regs_o    (regs_d),
    .result_o  (result_d)
  );

  assign out_valid_o       = out_valid_q;
  assign target_o          = result_q.target;
  assign mapped_address_o  = result_q.mapped_address;
  assign register_loaded_o = result_q.register_loaded;

  // The shift counter wraps to zero on the fifth bit, so it never rests above four.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    regs_q.shift_count <= 3'd4)
    else $error("shift count out of range");

  // Mapper state moves only when an item leaves the input register.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(regs_q))
    else $error("mapper state changed without an item");

  // A completed register load is a register write and addresses no memory.
  a_load_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && register_loaded_o |-> target_o == TGT_NONE)
    else $error("register load with a target");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && target_o == TGT_NONE |-> mapped_address_o == '0)
    else $error("nonzero address without a target");

  // The input side stalls only while an item waits in the input register.
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_o && out_stall_i)
    else $error("input stalled without a backlog");

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the serial-loaded bank mapper.
`timescale 1ns / 1ps
module tb;
  import smap_pkg::*;

  // PRG bank modes and nametable mirroring codes held in the control register.
  localparam logic [1:0] PrgFixFirst      = 2'd2;
  localparam logic [1:0] PrgFixLast       = 2'd3;
  localparam logic [1:0] MirrorPage0      = 2'd0;
  localparam logic [1:0] MirrorPage1      = 2'd1;
  localparam logic [1:0] MirrorVertical   = 2'd2;

  localparam int unsigned NumSettings = 10;
  localparam int unsigned ItemsPerSetting = 195;
  localparam int unsigned PrgSizes[NumSettings] = '{32, 1, 2, 4, 8, 16, 32, 1, 24, 16};
  localparam int unsigned ChrSizes[NumSettings] = '{16, 0, 1, 2, 4, 8, 0, 16, 3, 0};

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_BURSTS
  } stall_style_e;

  logic                 clk_i;
  logic                 rst_ni            = 1'b0;
  logic                 in_valid_i        = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           mode_i            = '0;
  logic [AddrW-1:0]     address_i         = '0;
  logic [DataW-1:0]     data_i            = '0;
  logic                 out_valid_o;
  logic                 out_stall_i       = 1'b0;
  logic [2:0]           target_o;
  logic [MapW-1:0]      mapped_address_o;
  logic                 register_loaded_o;
  logic                 cfg_we_i          = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i       = '0;
  logic [CfgDatW-1:0]   cfg_data_i        = '0;

  serial_loaded_bank_mapper DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .mode_i            (mode_i),
    .address_i         (address_i),
    .data_i            (data_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .target_o          (target_o),
    .mapped_address_o  (mapped_address_o),
    .register_loaded_o (register_loaded_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  map_regs_t     mapper_regs;
  map_cfg_t      mapper_sizes;
  map_result_t   expected_maps[$];

  int unsigned   items_sent       = 0;
  int unsigned   results_checked  = 0;
  int unsigned   loads_expected   = 0;
  int unsigned   settings_visited = 0;
  int unsigned   error_count      = 0;
  int unsigned   burst_left       = 0;
  bit            sender_steady    = 1'b0;

  stall_style_e  stall_style = STALL_NONE;
  int unsigned   style_left  = 0;
  int unsigned   stall_run   = 0;
  bit            stall_level = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run limit, several times the slowest legal run.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (error_count < 40) begin
      $display("MISMATCH result %0d: %s got 0x%0h want 0x%0h", results_checked, what, got,
               want);
    end
    error_count++;
  endtask

  // CPU space translation: PRG ROM banking, PRG RAM window, or nothing.
  function automatic map_result_t cpu_map(logic [15:0] a);
    map_result_t r;
    logic [4:0]  size_mask;
    logic [4:0]  inner;
    logic [4:0]  outer;
    logic [4:0]  sel;
    logic [4:0]  bank;
    r = '{target: TGT_NONE, mapped_address: '0, register_loaded: 1'b0};
    size_mask = 5'(mapper_sizes.prg_rom_banks - 6'd1);
    inner = size_mask & 5'h0F;
    // With more than 256KB of PRG, CHR0 bit 4 picks the 256KB half.
    outer = size_mask[4] ? (mapper_regs.chr_bank_low & 5'h10) : 5'd0;
    sel = mapper_regs.prg_bank & inner;
    if (a[15]) begin
      case (mapper_regs.prg_mode)
        PrgFixFirst: bank = a[14] ? (outer | sel) : outer;
        PrgFixLast:  bank = a[14] ? (outer | inner) : (outer | sel);
        default:     bank = outer | (sel & 5'h0E) | {4'd0, a[14]};
      endcase
      r.target = TGT_PRG_ROM;
      r.mapped_address = {bank, a[13:0]};
    end else if (a >= 16'h6000 && mapper_regs.ram_enabled) begin
      r.target = TGT_PRG_RAM;
      r.mapped_address = {6'd0, a[12:0]};
    end
    return r;
  endfunction

  // Expected translation of one access; advances the mapper state it keeps.
  function automatic map_result_t apply_access(mode_e m, logic [15:0] a, logic [7:0] d);
    map_result_t r;
    logic [4:0]  bank;
    logic [4:0]  chr_mask;
    logic        page;
    r = '{target: TGT_NONE, mapped_address: '0, register_loaded: 1'b0};
    case (m)
      MODE_CPU_READ: r = cpu_map(a);
      MODE_CPU_WRITE: begin
        if (!a[15]) begin
          r = cpu_map(a);
        end else if (d[7]) begin
          mapper_regs.shift_value = 5'd0;
          mapper_regs.shift_count = 3'd0;
          mapper_regs.prg_mode = PrgFixLast;
        end else begin
          mapper_regs.shift_value = {d[0], mapper_regs.shift_value[4:1]};
          mapper_regs.shift_count = mapper_regs.shift_count + 3'd1;
          if (mapper_regs.shift_count >= 3'd5) begin
            case (reg_sel_e'(a[14:13]))
              REG_CONTROL: begin
                mapper_regs.mirroring = mapper_regs.shift_value[1:0];
                mapper_regs.prg_mode = mapper_regs.shift_value[3:2];
                mapper_regs.chr_4k_mode = mapper_regs.shift_value[4];
              end
              REG_CHR0: mapper_regs.chr_bank_low = mapper_regs.shift_value;
              REG_CHR1: mapper_regs.chr_bank_high = mapper_regs.shift_value;
              default: begin
                mapper_regs.prg_bank = mapper_regs.shift_value;
                mapper_regs.ram_enabled = !mapper_regs.shift_value[4];
              end
            endcase
            mapper_regs.shift_value = 5'd0;
            mapper_regs.shift_count = 3'd0;
            r.register_loaded = 1'b1;
          end
        end
      end
      MODE_PATTERN: begin
        // In 8KB mode the low bank bit comes from A12 instead of the register.
        if (mapper_regs.chr_4k_mode) begin
          bank = a[12] ? mapper_regs.chr_bank_high : mapper_regs.chr_bank_low;
        end else begin
          bank = {mapper_regs.chr_bank_low[4:1], a[12]};
        end
        if (mapper_sizes.chr_rom_banks != 5'd0) begin
          chr_mask = 5'((6'(mapper_sizes.chr_rom_banks) << 1) - 6'd1);
          bank = bank & chr_mask;
          r.target = TGT_CHR_ROM;
        end else begin
          bank = bank & 5'd1;
          r.target = TGT_CHR_RAM;
        end
        r.mapped_address = {2'd0, bank, a[11:0]};
      end
      default: begin
        case (mapper_regs.mirroring)
          MirrorPage0:    page = 1'b0;
          MirrorPage1:    page = 1'b1;
          MirrorVertical: page = a[10];
          default:        page = a[11];
        endcase
        r.target = TGT_NT;
        r.mapped_address = {8'd0, page, a[9:0]};
      end
    endcase
    return r;
  endfunction

  // Sends one item in bursts with random gaps; predicts it once accepted.
  task automatic send_access(mode_e m, logic [15:0] a, logic [7:0] d);
    int unsigned gap;
    map_result_t want;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = 0;
      if (!sender_steady && $urandom_range(0, 3) != 0) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3);
      end
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    mode_i     <= m;
    address_i  <= a;
    data_i     <= d;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    want = apply_access(m, a, d);
    expected_maps.push_back(want);
    if (want.register_loaded) loads_expected++;
    items_sent++;
  endtask

  // Five serial writes that load one register, optionally mixed with other accesses.
  task automatic serial_load(reg_sel_e sel, logic [4:0] value, bit interleave);
    logic [15:0] a;
    for (int i = 0; i < 5; i++) begin
      a = (i == 4) ? {1'b1, sel, 13'($urandom)} : 16'($urandom_range(16'h8000, 16'hFFFF));
      send_access(MODE_CPU_WRITE, a, {1'b0, 6'($urandom), value[i]});
      if (interleave && $urandom_range(0, 3) == 0) send_bus_access();
    end
  endtask

  task automatic send_bus_access();
    int unsigned pick;
    logic [15:0] a;
    logic [7:0]  d;
    bit          coin;
    pick = $urandom_range(0, 9);
    a = 16'($urandom);
    d = 8'($urandom);
    coin = $urandom_range(0, 1);
    case (pick)
      0, 1, 2: send_access(MODE_CPU_READ, {1'b1, a[14:0]}, d);
      3:       send_access(coin ? MODE_CPU_WRITE : MODE_CPU_READ, {3'b011, a[12:0]}, d);
      4:       send_access(coin ? MODE_CPU_WRITE : MODE_CPU_READ, {1'b0, a[14:0]}, d);
      5, 6:    send_access(MODE_PATTERN, a, d);
      7, 8:    send_access(MODE_NAMETABLE, a, d);
      default: send_access(MODE_CPU_READ, a, d);
    endcase
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_maps.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_sizes(int unsigned prg, int unsigned chr);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_PRG_BANKS;
    cfg_data_i  <= prg[CfgDatW-1:0];
    @(posedge clk_i);
    mapper_sizes.prg_rom_banks = prg[PrgCfgW-1:0];
    cfg_index_i <= CFG_CHR_BANKS;
    cfg_data_i  <= chr[CfgDatW-1:0];
    @(posedge clk_i);
    mapper_sizes.chr_rom_banks = chr[ChrCfgW-1:0];
    cfg_we_i <= 1'b0;
    settings_visited++;
  endtask

  task automatic test_power_on_defaults();
    send_access(MODE_CPU_READ, 16'h8000, 8'h00);
    send_access(MODE_CPU_READ, 16'hFFFF, 8'hFF);
    send_access(MODE_CPU_READ, 16'h6000, 8'h00);
    send_access(MODE_CPU_READ, 16'h5FFF, 8'h00);
    send_access(MODE_CPU_WRITE, 16'h7ABC, 8'h55);
    send_access(MODE_PATTERN, 16'h0000, 8'h00);
    send_access(MODE_PATTERN, 16'hFFFF, 8'hFF);
    send_access(MODE_NAMETABLE, 16'h2C00, 8'h00);
    send_access(MODE_NAMETABLE, 16'hFFFF, 8'hFF);
  endtask

  task automatic test_serial_load_and_reset();
    // Vertical mirroring, first bank fixed, 8KB CHR.
    serial_load(REG_CONTROL, 5'b01010, 1'b0);
    send_access(MODE_NAMETABLE, 16'h2400, 8'h00);
    send_access(MODE_CPU_READ, 16'h8000, 8'h00);
    // A write with bit 7 set clears the shifter and restores fix-last mode.
    send_access(MODE_CPU_WRITE, 16'hFFFF, 8'hFF);
    send_access(MODE_CPU_READ, 16'hC000, 8'h00);
  endtask

  task automatic test_prg_ram_disable();
    serial_load(REG_PRG, 5'h1F, 1'b0);
    send_access(MODE_CPU_READ, 16'h7FFF, 8'h00);
    send_access(MODE_CPU_WRITE, 16'h6000, 8'hAA);
  endtask

  task automatic run_traffic_sequence();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      if ($urandom_range(0, 2) == 0) begin
        send_access(MODE_CPU_WRITE, 16'($urandom_range(16'h8000, 16'hFFFF)),
                    8'h80 | 8'($urandom));
      end
      serial_load(reg_sel_e'($urandom_range(0, 3)), 5'($urandom), $urandom_range(0, 1));
      n = $urandom_range(1, 6);
      repeat (n) send_bus_access();
    end else if (kind <= 7) begin
      // An abandoned load, sometimes cut short by a shifter reset.
      n = $urandom_range(1, 4);
      repeat (n) begin
        send_access(MODE_CPU_WRITE, 16'($urandom_range(16'h8000, 16'hFFFF)),
                    {1'b0, 7'($urandom)});
      end
      if ($urandom_range(0, 1) == 0) begin
        send_access(MODE_CPU_WRITE, 16'($urandom_range(16'h8000, 16'hFFFF)),
                    8'h80 | 8'($urandom));
      end
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) send_access(mode_e'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    int unsigned phase_end;
    for (int p = 0; p < NumSettings; p++) begin
      write_sizes(PrgSizes[p], ChrSizes[p]);
      sender_steady = ($urandom_range(0, 3) == 0);
      phase_end = items_sent + ItemsPerSetting;
      while (items_sent < phase_end) run_traffic_sequence();
    end
    sender_steady = 1'b0;
  endtask

  // Result stall pattern; a new style is picked at random once the current one runs out.
  always @(posedge clk_i) begin
    if (style_left == 0) begin
      stall_style = stall_style_e'($urandom_range(0, 3));
      style_left = $urandom_range(40, 300);
    end
    style_left--;
    case (stall_style)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 7) == 0);
      STALL_HEAVY: out_stall_i <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_run == 0) begin
          stall_level = !stall_level;
          stall_run = stall_level ? $urandom_range(1, 30) : $urandom_range(1, 10);
        end
        stall_run--;
        out_stall_i <= stall_level;
      end
    endcase
  end

  always @(posedge clk_i) begin
    map_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_maps.size() == 0) begin
        report_mismatch("result with no access pending", {29'd0, target_o}, 32'd0);
      end else begin
        want = expected_maps.pop_front();
        if (target_o !== want.target) begin
          report_mismatch("target", {29'd0, target_o}, {29'd0, want.target});
        end
        if (mapped_address_o !== want.mapped_address) begin
          report_mismatch("mapped_address", {13'd0, mapped_address_o},
                          {13'd0, want.mapped_address});
        end
        if (register_loaded_o !== want.register_loaded) begin
          report_mismatch("register_loaded", {31'd0, register_loaded_o},
                          {31'd0, want.register_loaded});
        end
      end
      results_checked++;
    end
  end

  initial begin
    mapper_regs = RegsReset;
    mapper_sizes.prg_rom_banks = PrgBanksReset;
    mapper_sizes.chr_rom_banks = ChrBanksReset;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_power_on_defaults();
    test_serial_load_and_reset();
    test_prg_ram_disable();
    test_random_traffic();

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Ran %0d accesses across %0d bank size settings with %0d register loads.",
             items_sent, settings_visited, loads_expected);
    $display("Checked %0d results, %0d mismatches.", results_checked, error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
